>>> rtl/core/crcws_pkg.sv
// Package: CRC-16 constants and word-level helper functions.
package crcws_pkg;

	localparam int unsigned WORD_W = 16;

	localparam logic [WORD_W-1:0] CRC_POLY = 16'h8005;
	localparam logic [WORD_W-1:0] HI_MASK  = 16'hff00;
	localparam logic [WORD_W-1:0] LO_MASK  = 16'h00ff;

	typedef logic [WORD_W-1:0] word_t;

	function automatic word_t swap_bytes(input word_t v);
		word_t r;
		r = ((v << 8) & HI_MASK) | ((v >> 8) & LO_MASK);
		return r;
	endfunction

	function automatic word_t shift_word(input word_t crc, input word_t msg);
		word_t r;
		logic  top;
		r = crc;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			top = r[WORD_W-1];
			r   = {r[WORD_W-2:0], msg[b]};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/crcws_if.sv
// Interfaces: frame word channel and checksum channel.
interface crcws_frame_if;
	import crcws_pkg::*;
	logic  valid;
	logic  ready;
	word_t word;
	logic  first;
	logic  last;

	modport source(output valid, output word, output first, output last, input ready);
	modport sink(input valid, input word, input first, input last, output ready);
endinterface

interface crcws_result_if;
	import crcws_pkg::*;
	logic  valid;
	logic  ready;
	word_t checksum;

	modport source(output valid, output checksum, input ready);
	modport sink(input valid, input checksum, output ready);
endinterface

>>> rtl/core/crcws_step.sv
// Next CRC register value for one frame word: load or 16-bit shift.
module crcws_step
	import crcws_pkg::*;
(
	input  word_t crc,
	input  word_t word,
	input  logic  first,
	output word_t next_crc
);

	word_t sw;

	assign sw       = swap_bytes(word);
	assign next_crc = first ? sw : shift_word(crc, sw);

endmodule

>>> rtl/core/crc16_word_stream_unit.sv
// Top level: CRC-16 (poly 0x8005) over a stream of 16-bit frame words.
//
//   channel | role | payload               | beat
//   frame   | sink | word, first, last     | one frame word
//   result  | src  | checksum              | one checksum per word marked last
//
// One word per cycle sustained, unless a stalled result holds back a last word.
// Input register, then CRC step logic, then the result register.
// Reset clears the CRC register and all valid flags.
// A stalled result blocks only a further last word; words before it keep flowing, words after it wait.
module crc16_word_stream_unit
	import crcws_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	crcws_frame_if.sink    frame,
	crcws_result_if.source result
);

	logic  valid_s1;
	word_t word_s1;
	logic  first_s1;
	logic  last_s1;

	word_t crc_q;
	word_t next_crc;
	logic  out_valid_q;
	word_t checksum_q;

	logic  out_free;
	logic  adv_s1;

	assign out_free    = !out_valid_q || result.ready;
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign frame.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			word_s1  <= frame.word;
			first_s1 <= frame.first;
			last_s1  <= frame.last;
		end
	end

	crcws_step u_step (
		.crc      (crc_q),
		.word     (word_s1),
		.first    (first_s1),
		.next_crc (next_crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				crc_q <= next_crc;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			checksum_q <= swap_bytes(next_crc);
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

endmodule

>>> rtl/core/crcws_checker.sv
// Port-level checks for the CRC-16 word stream unit, bound to the top level.
module crcws_checker
	import crcws_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  frame_ready,
	input logic  result_valid,
	input logic  result_ready,
	input word_t result_checksum
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_ready |-> (result_valid && !result_ready))
		else $error("frame stalled without a stalled result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("result beat dropped while stalled");

	a_checksum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> $stable(result_checksum))
		else $error("checksum changed while stalled");

endmodule

bind crc16_word_stream_unit crcws_checker u_crcws_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.frame_ready     (frame.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_checksum (result.checksum)
);
